[hdl/pfa_pkg.sv]
package pfa_pkg;

  localparam int unsigned MAX_PAGES   = 16384;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned IDX_W       = $clog2(MAX_PAGES);
  localparam int unsigned DEPTH_W     = $clog2(MAX_PAGES + 1);

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PAGE_ADDR_W = 26;
  localparam int unsigned REF_W       = 8;
  localparam int unsigned CFG_W       = 27;

  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [CFG_W-1:0] KERNEL_END_RST = '0;
  localparam logic [CFG_W-1:0] PHYS_TOP_RST   = CFG_W'(67108864);

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_KERNEL_END = 1'b0;
  localparam logic REG_PHYS_TOP   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_INC   = 3'd2,
    CMD_DEC   = 3'd3,
    CMD_GET   = 3'd4,
    CMD_SEED  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_ALIGN = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear;    // write one zero into the count store during the sweep
    logic capture;  // register the incoming command and issue the RAM reads
    logic commit;   // perform the writes and load the result register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;  // the sweep is writing its final entry
    logic out_busy;    // result register full and not being taken
  } dp_sts_t;

endpackage

[hdl/pfa_if.sv]
interface pfa_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [pfa_pkg::CMD_W-1:0]        command;
  logic [pfa_pkg::ADDR_W-1:0]       phys_addr;

  modport source (output valid, command, phys_addr, input ready);
  modport sink   (input valid, command, phys_addr, output ready);
endinterface

interface pfa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pfa_pkg::STATUS_W-1:0]     status;
  logic [pfa_pkg::PAGE_ADDR_W-1:0]  page_addr;
  logic [pfa_pkg::REF_W-1:0]        ref_value;

  modport source (output valid, status, page_addr, ref_value, input ready);
  modport sink   (input valid, status, page_addr, ref_value, output ready);
endinterface

[hdl/pfa_ram.sv]
module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pfa_ctrl.sv]
module pfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfa_pkg::dp_sts_t    sts_i,
  output pfa_pkg::ctrl_cmd_t  cmd_o
);

  pfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      pfa_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pfa_pkg::S_EXEC;
        end
      end
      pfa_pkg::S_EXEC: begin
        // The RAM read data holds until the next capture, so waiting here is safe.
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = pfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfa_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

[hdl/pfa_dp.sv]
module pfa_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfa_pkg::ctrl_cmd_t               cmd_i,
  output pfa_pkg::dp_sts_t                 sts_o,
  input  logic [pfa_pkg::CMD_W-1:0]        command_i,
  input  logic [pfa_pkg::ADDR_W-1:0]       phys_addr_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pfa_pkg::STATUS_W-1:0]     status_o,
  output logic [pfa_pkg::PAGE_ADDR_W-1:0]  page_addr_o,
  output logic [pfa_pkg::REF_W-1:0]        ref_value_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfa_pkg::PADDR_W-1:0]      paddr,
  input  logic [pfa_pkg::PDATA_W-1:0]      pwdata,
  output logic [pfa_pkg::PDATA_W-1:0]      prdata
);

  // Configuration registers.
  logic [pfa_pkg::CFG_W-1:0] kend_q, ptop_q;
  logic                      cfg_we;

  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q <= pfa_pkg::KERNEL_END_RST;
      ptop_q <= pfa_pkg::PHYS_TOP_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        pfa_pkg::REG_KERNEL_END: kend_q <= pwdata[pfa_pkg::CFG_W-1:0];
        pfa_pkg::REG_PHYS_TOP:   ptop_q <= pwdata[pfa_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pfa_pkg::REG_KERNEL_END: prdata = pfa_pkg::PDATA_W'(kend_q);
      pfa_pkg::REG_PHYS_TOP:   prdata = pfa_pkg::PDATA_W'(ptop_q);
      default:                 prdata = '0;
    endcase
  end

  // Captured command and control state.
  pfa_pkg::cmd_e                cmd_q;
  logic [pfa_pkg::ADDR_W-1:0]   pa_q;
  logic [pfa_pkg::DEPTH_W-1:0]  depth_q, depth_d;
  logic [pfa_pkg::IDX_W-1:0]    clr_cnt_q;
  logic                         out_valid_q;
  logic [pfa_pkg::STATUS_W-1:0] status_q;
  logic [pfa_pkg::PAGE_ADDR_W-1:0] page_addr_q;
  logic [pfa_pkg::REF_W-1:0]    ref_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= pfa_pkg::cmd_e'(command_i);
      pa_q  <= phys_addr_i;
    end
  end

  // Memories.
  logic                       refs_we, refs_wr;
  logic [pfa_pkg::IDX_W-1:0]  refs_waddr, refs_wsel;
  logic [pfa_pkg::REF_W-1:0]  refs_wdata, refs_wval, refs_rdata;
  logic                       stk_we, stk_push, pop;
  logic [pfa_pkg::IDX_W-1:0]  stk_rdata, stk_raddr, stk_waddr, idx;

  assign stk_raddr  = pfa_pkg::IDX_W'(depth_q - pfa_pkg::DEPTH_W'(1));
  assign stk_waddr  = pfa_pkg::IDX_W'(depth_q);
  assign refs_we    = cmd_i.clear | (cmd_i.commit & refs_wr);
  assign refs_waddr = cmd_i.clear ? clr_cnt_q : refs_wsel;
  assign refs_wdata = cmd_i.clear ? '0 : refs_wval;
  assign stk_we     = cmd_i.commit & stk_push;

  pfa_ram #(
    .WIDTH (pfa_pkg::REF_W),
    .DEPTH (pfa_pkg::MAX_PAGES)
  ) u_refs (
    .clk_i   (clk_i),
    .we_i    (refs_we),
    .waddr_i (refs_waddr),
    .wdata_i (refs_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (phys_addr_i[pfa_pkg::PAGE_SHIFT +: pfa_pkg::IDX_W]),
    .rdata_o (refs_rdata)
  );

  pfa_ram #(
    .WIDTH (pfa_pkg::IDX_W),
    .DEPTH (pfa_pkg::MAX_PAGES)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (idx),
    .re_i    (cmd_i.capture),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Execute: checks and read-modify-write on the captured command.
  logic                           out_range, misaligned, full;
  logic [pfa_pkg::REF_W-1:0]      cur_eff, dec_val, inc_val;
  pfa_pkg::status_e               status_c;
  logic [pfa_pkg::PAGE_ADDR_W-1:0] page_addr_c;
  logic [pfa_pkg::REF_W-1:0]      ref_c;

  assign idx        = pa_q[pfa_pkg::PAGE_SHIFT +: pfa_pkg::IDX_W];
  assign out_range  = (pa_q < pfa_pkg::ADDR_W'(kend_q)) || (pa_q >= pfa_pkg::ADDR_W'(ptop_q))
                   || ((pa_q >> pfa_pkg::PAGE_SHIFT) >= pfa_pkg::ADDR_W'(pfa_pkg::MAX_PAGES));
  assign misaligned = pa_q[pfa_pkg::PAGE_SHIFT-1:0] != '0;
  assign full       = depth_q == pfa_pkg::DEPTH_W'(pfa_pkg::MAX_PAGES);
  assign cur_eff    = (cmd_q == pfa_pkg::CMD_SEED) ? pfa_pkg::REF_W'(1) : refs_rdata;
  assign dec_val    = (cur_eff != '0) ? cur_eff - pfa_pkg::REF_W'(1) : '0;
  assign inc_val    = refs_rdata + pfa_pkg::REF_W'(1);

  always_comb begin
    status_c    = pfa_pkg::ST_OK;
    page_addr_c = '0;
    ref_c       = '0;
    refs_wr     = 1'b0;
    refs_wsel   = idx;
    refs_wval   = '0;
    stk_push    = 1'b0;
    pop         = 1'b0;
    case (cmd_q) inside
      pfa_pkg::CMD_ALLOC: begin
        if (depth_q == '0) begin
          status_c = pfa_pkg::ST_EMPTY;
        end else begin
          pop         = 1'b1;
          refs_wr     = 1'b1;
          refs_wsel   = stk_rdata;
          refs_wval   = pfa_pkg::REF_W'(1);
          page_addr_c = pfa_pkg::PAGE_ADDR_W'({stk_rdata, {pfa_pkg::PAGE_SHIFT{1'b0}}});
          ref_c       = pfa_pkg::REF_W'(1);
        end
      end
      pfa_pkg::CMD_FREE, pfa_pkg::CMD_SEED: begin
        if (misaligned) begin
          status_c = pfa_pkg::ST_ALIGN;
        end else if (out_range) begin
          status_c = pfa_pkg::ST_RANGE;
        end else if (dec_val != '0) begin
          refs_wr   = 1'b1;
          refs_wval = dec_val;
          ref_c     = dec_val;
        end else if (full) begin
          status_c = pfa_pkg::ST_FULL;
          ref_c    = refs_rdata;
        end else begin
          refs_wr  = 1'b1;
          stk_push = 1'b1;
        end
      end
      pfa_pkg::CMD_INC: begin
        if (out_range) begin
          status_c = pfa_pkg::ST_RANGE;
        end else begin
          refs_wr   = 1'b1;
          refs_wval = inc_val;
          ref_c     = inc_val;
        end
      end
      pfa_pkg::CMD_DEC: begin
        if (out_range) begin
          status_c = pfa_pkg::ST_RANGE;
        end else begin
          refs_wr   = 1'b1;
          refs_wval = dec_val;
          ref_c     = dec_val;
        end
      end
      pfa_pkg::CMD_GET: begin
        if (out_range) begin
          status_c = pfa_pkg::ST_RANGE;
        end else begin
          ref_c = refs_rdata;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.commit && pop) begin
      depth_d = depth_q - pfa_pkg::DEPTH_W'(1);
    end else if (cmd_i.commit && stk_push) begin
      depth_d = depth_q + pfa_pkg::DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + pfa_pkg::IDX_W'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= status_c;
      page_addr_q <= page_addr_c;
      ref_q       <= ref_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign page_addr_o      = page_addr_q;
  assign ref_value_o      = ref_q;
  assign sts_o.clear_last = &clr_cnt_q;
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  // The stack depth never passes the number of pages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= pfa_pkg::DEPTH_W'(pfa_pkg::MAX_PAGES))
    else $error("free stack depth beyond page count");

  // A pop lowers the stack depth by one; a push needs a non-full stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && pop |=> depth_q == $past(depth_q) - pfa_pkg::DEPTH_W'(1))
    else $error("pop did not lower the stack depth by one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> !full && !pop)
    else $error("push into a full stack");

  // Each commit presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed command produced no result");

  // The result register is never overwritten while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

[hdl/refcounted_page_frame_allocator.sv]
// Channel    Direction  Handshake       Payload
// cmd_i      in         valid / ready   command, phys_addr
// rsp_o      out        valid / ready   status, page_addr, ref_value
// APB        in / out   psel, penable   paddr, pwdata, prdata (pready tied high)
//
// Each command transaction passes through an accept state, to take it and start the
// reads of the count RAM and the free stack RAM, and an execute state, to check it
// and write both back. After reset a clearing pass writes zero to every one of the
// 16384 count entries, one per cycle, so no command is accepted until it is done.
// A result waits in an output register; a stalled response channel holds the
// next command in its execute cycle until that register is free.
module refcounted_page_frame_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pfa_cmd_if.sink                      cmd_i,
  pfa_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [pfa_pkg::PDATA_W-1:0]  pwdata,
  output logic [pfa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  pfa_pkg::ctrl_cmd_t ctrl_cmd;
  pfa_pkg::dp_sts_t   dp_sts;

  // The register file answers every access in its first access cycle.
  assign pready = 1'b1;

  // The controller sequences the reset sweep and the accept / execute pair of
  // every transaction.
  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // The datapath holds the configuration registers, both RAMs, the stack depth
  // and the result register.
  pfa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .command_i   (cmd_i.command),
    .phys_addr_i (cmd_i.phys_addr),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .page_addr_o (rsp_o.page_addr),
    .ref_value_o (rsp_o.ref_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule
